### rtl/sult_pkg.sv
// sult_pkg: shared constants, codes and control types of the sorted list table
// depends on: nothing
package sult_pkg;

    // table geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // word field widths
    localparam int REQ_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STS_W   = 3;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // result status codes
    localparam logic [STS_W-1:0] STS_DONE     = 3'd0;
    localparam logic [STS_W-1:0] STS_FULL     = 3'd1;
    localparam logic [STS_W-1:0] STS_DUP      = 3'd2;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 3'd3;
    localparam logic [STS_W-1:0] STS_EMPTY    = 3'd4;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic rsp_hold;
    } t_dp_sts;

endpackage

### rtl/sult_req_if.sv
// sult_req_if: request channel, valid/ready with request code and value
// depends on: sult_pkg
interface sult_req_if;
    import sult_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

### rtl/sult_rsp_if.sv
// sult_rsp_if: response channel, valid/ready with status, position and count
// depends on: sult_pkg
interface sult_rsp_if;
    import sult_pkg::*;

    logic               valid;
    logic               ready;
    logic [STS_W-1:0]   status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output position, output count,
                    input ready);
    modport sink   (input valid, input status, input position, input count,
                    output ready);
endinterface

### rtl/sult_ctrl.sv
// sult_ctrl: two-state controller, captures a request word and fires the update
// depends on: sult_pkg
module sult_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  sult_pkg::t_dp_sts i_sts,
    output sult_pkg::t_dp_cmd o_cmd,
    output logic              o_req_ready
);
    import sult_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.rsp_hold) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = !i_sts.rsp_hold;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/sult_dp.sv
// sult_dp: entry cells, parallel compare, shift update and response register
// depends on: sult_pkg, sult_rsp_if
module sult_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sult_pkg::t_dp_cmd                   i_cmd,
    input  logic [sult_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [sult_pkg::VALUE_W-1:0] i_value,
    output sult_pkg::t_dp_sts                   o_sts,
    sult_rsp_if.source                          o_rsp
);
    import sult_pkg::*;

    logic [REQ_W-1:0]          r_req_type;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_entries [DEPTH];
    logic signed [VALUE_W-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          n_fill;
    logic                      r_rsp_valid;
    logic [STS_W-1:0]          r_status;
    logic [STS_W-1:0]          n_status;
    logic [POS_W-1:0]          r_position;
    logic [POS_W-1:0]          n_position;

    logic [DEPTH:0]   w_lt;
    logic [DEPTH:0]   w_edge;
    logic [DEPTH-1:0] w_eq;
    logic [CNT_W-1:0] w_idx;
    logic             w_hit;
    logic             w_full;
    logic             w_do_ins;
    logic             w_do_rem;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_value    <= i_value;
        end
    end

    // per-cell compare against the request value, masked by fill
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_lt[i] = (CNT_W'(i) < r_fill) && (r_entries[i] < r_value);
            w_eq[i] = (CNT_W'(i) < r_fill) && (r_entries[i] == r_value);
        end
        w_lt[DEPTH] = 1'b0;
    end

    // less-than vector is a thermometer: its edge marks the sorted place
    always_comb begin
        w_edge[0] = !w_lt[0];
        for (int i = 1; i <= DEPTH; i++) begin
            w_edge[i] = w_lt[i-1] && !w_lt[i];
        end
        w_idx = '0;
        for (int i = 0; i <= DEPTH; i++) begin
            if (w_edge[i]) begin
                w_idx = w_idx | CNT_W'(i);
            end
        end
        w_hit  = |(w_eq & w_edge[DEPTH-1:0]);
        w_full = (r_fill == CNT_W'(DEPTH));
    end

    // request decode
    always_comb begin
        n_status   = STS_DONE;
        n_position = '0;
        w_do_ins   = 1'b0;
        w_do_rem   = 1'b0;
        case (r_req_type)
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = STS_FULL;
                end else if (w_hit) begin
                    n_status = STS_DUP;
                end else begin
                    w_do_ins   = 1'b1;
                    n_position = POS_W'(w_idx);
                end
            end
            REQ_REMOVE: begin
                if (w_hit) begin
                    w_do_rem   = 1'b1;
                    n_position = POS_W'(w_idx);
                end else begin
                    n_status = STS_NOTFOUND;
                end
            end
            REQ_SEARCH: begin
                if (r_fill == '0) begin
                    n_status = STS_EMPTY;
                end else if (w_hit) begin
                    n_position = POS_W'(w_idx);
                end else begin
                    n_status = STS_NOTFOUND;
                end
            end
            default: begin
                n_status = STS_DONE;
            end
        endcase
    end

    // one-step shift: up from the sorted place on insert, down on remove
    always_comb begin
        n_fill = r_fill;
        if (w_do_ins) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (w_do_rem) begin
            n_fill = r_fill - CNT_W'(1);
        end
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (w_do_ins) begin
                if (CNT_W'(i) == w_idx) begin
                    n_entries[i] = r_value;
                end else if ((i > 0) && (CNT_W'(i) > w_idx)) begin
                    n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                end
            end else if (w_do_rem) begin
                if ((i < DEPTH - 1) && (CNT_W'(i) >= w_idx)) begin
                    n_entries[i] = r_entries[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    end

    // entry cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_fill <= n_fill;
        end
    end

    // response register, holds until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status   <= n_status;
            r_position <= n_position;
        end
    end

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.position = r_position;
    assign o_rsp.count    = COUNT_W'(r_fill);

    assign o_sts.rsp_hold = r_rsp_valid && !o_rsp.ready;

endmodule

### rtl/sorted_unique_list_table.sv
// sorted_unique_list_table: top level, controller plus datapath on two channels
// depends on: sult_pkg, sult_req_if, sult_rsp_if, sult_ctrl, sult_dp
//
//   channel  dir  handshake     word
//   i_req    in   valid/ready   req_type[1:0], value[31:0] signed
//   o_rsp    out  valid/ready   status[2:0], position[3:0], count[4:0]
//
// a request is captured, then handled by a single compare-and-shift over all cells
// the compare covers every cell in parallel and the shift moves entries by one step
// the exec cycle waits while a previous response sits untaken in the output register
// a new request is taken while the last response still waits
// reset (synchronous, active low) clears the fill count and handshake state only
module sorted_unique_list_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sult_req_if.sink   i_req,
    sult_rsp_if.source o_rsp
);
    import sult_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_req_ready;

    // controller
    sult_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_req_ready (w_req_ready)
    );

    assign i_req.ready = w_req_ready;

    // datapath
    sult_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_type (i_req.req_type),
        .i_value    (i_req.value),
        .o_sts      (w_sts),
        .o_rsp      (o_rsp)
    );

`ifndef SYNTHESIS
    // count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (CNT_W'(o_rsp.count) <= CNT_W'(DEPTH)))
        else $error("count above depth");

    // a full refusal only happens with a full table
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == STS_FULL)) |-> (o_rsp.count == COUNT_W'(DEPTH)))
        else $error("full status with room left");

    // position is zero on every non-done status
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STS_DONE)) |-> (o_rsp.position == '0))
        else $error("position set on failed request");

    // controller is busy the cycle after taking a request
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");
`endif

endmodule

### tb/sult_table_checker.sv
`timescale 1ns / 100ps
// sult_table_checker: watches the request and response channels, keeps its own copy of the table
// depends on: sult_pkg, sult_req_if, sult_rsp_if
module sult_table_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sult_req_if  i_req,
    sult_rsp_if  i_rsp,
    output int   o_mismatches,
    output int   o_pending
);
    import sult_pkg::*;

    typedef struct packed {
        logic [STS_W-1:0]   status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_table_result;

    // shadow of the table, only the first table_fill cells are meaningful
    logic signed [VALUE_W-1:0] table_cells [DEPTH];
    int                        table_fill = 0;
    t_table_result             expected_words [$];
    int                        mismatch_count = 0;
    t_table_result             got_word;
    t_table_result             want_word;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // apply one request to the shadow table and work out its response word
    task automatic apply_request(input logic [REQ_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] val,
                                 output t_table_result res);
        int place;
        int k;
        bit hit;
        res.status   = STS_DONE;
        res.position = '0;
        place = 0;
        while (place < table_fill && table_cells[place] < val)
            place++;
        hit = (place < table_fill) && (table_cells[place] == val);
        case (op)
            REQ_INSERT: begin
                if (table_fill >= DEPTH) begin
                    res.status = STS_FULL;
                end else if (hit) begin
                    res.status = STS_DUP;
                end else begin
                    for (k = table_fill; k > place; k--)
                        table_cells[k] = table_cells[k-1];
                    table_cells[place] = val;
                    table_fill++;
                    res.position = place[POS_W-1:0];
                end
            end
            REQ_REMOVE: begin
                if (hit) begin
                    for (k = place; k + 1 < table_fill; k++)
                        table_cells[k] = table_cells[k+1];
                    table_fill--;
                    res.position = place[POS_W-1:0];
                end else begin
                    res.status = STS_NOTFOUND;
                end
            end
            REQ_SEARCH: begin
                if (table_fill == 0)
                    res.status = STS_EMPTY;
                else if (hit)
                    res.position = place[POS_W-1:0];
                else
                    res.status = STS_NOTFOUND;
            end
            // unused code leaves the table alone
            default: ;
        endcase
        res.count = table_fill[COUNT_W-1:0];
    endtask

    // compare taken response words, then record new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_fill = 0;
            expected_words.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got_word.status   = i_rsp.status;
                got_word.position = i_rsp.position;
                got_word.count    = i_rsp.count;
                if (expected_words.size() == 0) begin
                    report_mismatch("response word with none outstanding, status",
                                    got_word.status, -1);
                end else begin
                    want_word = expected_words.pop_front();
                    if (got_word.status !== want_word.status)
                        report_mismatch("status", got_word.status, want_word.status);
                    if (got_word.position !== want_word.position)
                        report_mismatch("position", got_word.position, want_word.position);
                    if (got_word.count !== want_word.count)
                        report_mismatch("count", got_word.count, want_word.count);
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_request(i_req.req_type, i_req.value, want_word);
                expected_words.push_back(want_word);
            end
        end
        o_pending    <= expected_words.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### tb/sorted_unique_list_table_tb.sv
`timescale 1ns / 100ps
// sorted_unique_list_table_tb: request stimulus, response back-pressure and final verdict
// depends on: sult_pkg, sult_req_if, sult_rsp_if, sorted_unique_list_table, sult_table_checker
module sorted_unique_list_table_tb;
    import sult_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1050;
    localparam int CALM_WORDS   = 150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int POOL_MAX     = 24;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;
    bit   no_idle = 1'b0;
    int   mismatches;
    int   pending;
    int   cycles = 0;

    logic signed [VALUE_W-1:0] value_pool [POOL_MAX];

    sult_req_if req_ch ();
    sult_rsp_if rsp_ch ();

    sorted_unique_list_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sult_table_checker u_table_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // response back-pressure in random bursts
    initial begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold != 0) begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                hold = $urandom_range(0, 9);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // one request word, with an optional idle burst ahead of it
    task automatic send_word(input logic [REQ_W-1:0] op, input logic signed [VALUE_W-1:0] val);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.value    <= val;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // hold off requests until every response word is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // operation mix per round flavor: 0 fill, 1 drain, 2 mixed
    function automatic logic [REQ_W-1:0] pick_op(input int flavor);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return REQ_UNUSED;
        case (flavor)
            0:       return (roll < 75) ? REQ_INSERT : (roll < 90) ? REQ_SEARCH : REQ_REMOVE;
            1:       return (roll < 70) ? REQ_REMOVE : (roll < 85) ? REQ_SEARCH : REQ_INSERT;
            default: return (roll < 36) ? REQ_INSERT : (roll < 68) ? REQ_REMOVE : REQ_SEARCH;
        endcase
    endfunction

    // mostly values from the round pool so hits and duplicates are common
    function automatic logic signed [VALUE_W-1:0] pick_value(input int pool_size);
        if ($urandom_range(0, 99) < 12)
            return $urandom;
        return value_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    // stimulus
    initial begin
        int sent;
        int rounds;
        int flavor;
        int round_len;
        int pool_size;
        int i;
        int n;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_INSERT;
        req_ch.value    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, every operation, refused requests
        send_word(REQ_SEARCH, 32'sd0);
        send_word(REQ_REMOVE, 32'sd0);
        send_word(REQ_INSERT, 32'sd0);
        send_word(REQ_INSERT, VAL_MIN);
        send_word(REQ_INSERT, VAL_MAX);
        send_word(REQ_INSERT, 32'sd0);
        send_word(REQ_INSERT, -32'sd1);
        send_word(REQ_INSERT, 32'sd1);
        send_word(REQ_INSERT, 32'sh5555_5555);
        send_word(REQ_INSERT, 32'shaaaa_aaaa);
        send_word(REQ_SEARCH, VAL_MIN);
        send_word(REQ_SEARCH, VAL_MAX);
        send_word(REQ_SEARCH, 32'sd7);
        send_word(REQ_UNUSED, 32'sd1);
        send_word(REQ_REMOVE, 32'sd7);
        send_word(REQ_REMOVE, 32'sd0);
        send_word(REQ_REMOVE, VAL_MAX);
        send_word(REQ_REMOVE, VAL_MIN);
        send_word(REQ_REMOVE, -32'sd1);
        send_word(REQ_REMOVE, 32'sd1);
        send_word(REQ_REMOVE, 32'sh5555_5555);
        send_word(REQ_REMOVE, 32'shaaaa_aaaa);
        send_word(REQ_SEARCH, VAL_MAX);
        wait_drained();

        // random rounds, each with a fresh value pool and a flavor
        sent   = 0;
        rounds = 0;
        while (sent < RANDOM_WORDS) begin
            flavor    = (rounds == 0) ? 0 : $urandom_range(0, 2);
            pool_size = (flavor == 0) ? POOL_MAX : $urandom_range(6, POOL_MAX);
            value_pool[0] = VAL_MIN;
            value_pool[1] = VAL_MAX;
            value_pool[2] = 32'sd0;
            value_pool[3] = -32'sd1;
            for (i = 4; i < POOL_MAX; i++)
                value_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 40) - 20;
            round_len = (rounds == 0) ? 60 : $urandom_range(20, 80);
            no_idle   = (RANDOM_WORDS - sent <= CALM_WORDS) || ($urandom_range(0, 4) == 0);
            for (n = 0; n < round_len && sent < RANDOM_WORDS; n++) begin
                send_word(pick_op(flavor), pick_value(pool_size));
                sent++;
            end
            rounds++;
            if (rounds % 5 == 0)
                wait_drained();
        end

        // drain and settle
        no_idle = 1'b1;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
